// ----- src/pfar_pkg.sv -----
package pfar_pkg;

	localparam int FRAME_COUNT = 16;
	localparam int STAMP_BITS  = 32;
	localparam int IDX_W       = $clog2(FRAME_COUNT);
	localparam int FREE_W      = $clog2(FRAME_COUNT + 1);

	localparam int IN_DATA_W   = 24;
	localparam int OUT_DATA_W  = 32;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [STAMP_BITS-1:0] stamp_t;
	typedef logic [FREE_W-1:0]     free_t;

	// request commands
	localparam logic [1:0] CMD_ALLOC  = 2'd0;
	localparam logic [1:0] CMD_FREE   = 2'd1;
	localparam logic [1:0] CMD_ACCESS = 2'd2;

	// result status codes
	localparam logic [2:0] ST_ALLOC_FREE  = 3'd0;
	localparam logic [2:0] ST_ALLOC_EVICT = 3'd1;
	localparam logic [2:0] ST_FREED       = 3'd2;
	localparam logic [2:0] ST_NOP         = 3'd3;
	localparam logic [2:0] ST_ACCESSED    = 3'd4;

	typedef struct packed {
		logic load;
		logic start_clock;
		logic clock_step;
		logic start_lru;
		logic lru_step;
		logic commit;
	} pfar_cmd_t;

	typedef struct packed {
		logic need_evict;
		logic use_lru;
		logic clock_done;
		logic lru_last;
		logic out_free;
	} pfar_stat_t;

	function automatic idx_t adv_hand(input idx_t h);
		return (h == idx_t'(FRAME_COUNT - 1)) ? '0 : h + idx_t'(1);
	endfunction

endpackage

// ----- src/page_frame_allocator_replacement_unit.sv -----
// Physical frame allocator with page replacement over a 16-frame table.
// Each request (s_tuser = command) allocates the lowest free frame, frees a
// frame, or records an access (sets R, sets D on writes, stamps the frame
// with a running time counter). When no frame is free an allocate evicts a
// victim chosen by the policy register on the cfg port: 0 selects enhanced
// second chance (clock hand, up to four passes over the table looking for
// class 0, then 1, then 0, then 1, clearing R on class 2/3 frames as it
// goes), 1 selects least recently used (oldest stamp, lowest index on a
// tie). The victim's owner, page and write-back flag come back with the
// result. One request is handled at a time. Free, access and non-evicting
// allocate pass through the exec and commit states; a clock eviction adds
// one step per frame inspected by the hand (at most 64 frames, four passes);
// an LRU eviction adds a stamp scan over frames 1 to FRAME_COUNT-1, one
// frame per cycle through a single comparator. The result sits in an output
// register, so the next request is taken while it waits for m_tready.
// Policy writes are only legal while the block is idle.
module page_frame_allocator_replacement_unit (
	input  logic        clk,
	input  logic        arst_n,
	// config: policy select, 0 = second chance clock, 1 = LRU
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	// request
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // process_tag[7:0], page_number[15:8],
	                               // frame_index[19:16], is_write[20], zero pad
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	// result
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // result_frame[3:0], victim_owner[11:4],
	                               // victim_page[19:12], needs_writeback[20],
	                               // frames_free[25:21], zero pad
	output logic [2:0]  m_tuser    // status[2:0]
);
	import pfar_pkg::*;

	pfar_cmd_t  cmd;
	pfar_stat_t stat;

	// policy register has no back-pressure
	assign cfg_ready = 1'b1;

	pfar_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pfar_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req_user  (s_tuser),
		.req_data  (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_user  (m_tuser),
		.res_data  (m_tdata)
	);

`ifndef SYNTH
	// one request in flight: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while previous one in flight");

	// an eviction only happens with the table full
	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_ALLOC_EVICT) |-> (m_tdata[25:21] == 5'd0))
		else $error("eviction reported with free frames left");

	// victim fields are zero unless a frame was evicted
	a_victim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_ALLOC_EVICT) |-> (m_tdata[20:4] == 17'd0))
		else $error("victim data on a non-evicting result");

	// free count never exceeds the table size
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (32'(m_tdata[25:21]) <= FRAME_COUNT))
		else $error("free frame count out of range");
`endif

endmodule

// ----- src/pfar_ctrl.sv -----
module pfar_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  pfar_pkg::pfar_stat_t stat,
	output pfar_pkg::pfar_cmd_t  cmd
);
	import pfar_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_EXEC   = 5'b00010,
		S_CLOCK  = 5'b00100,
		S_LRU    = 5'b01000,
		S_COMMIT = 5'b10000
	} state_t;

	state_t state_q, state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.need_evict && stat.use_lru) begin
					cmd.start_lru = 1'b1;
					state_d       = S_LRU;
				end else if (stat.need_evict) begin
					cmd.start_clock = 1'b1;
					state_d         = S_CLOCK;
				end else begin
					state_d = S_COMMIT;
				end
			end
			S_CLOCK: begin
				cmd.clock_step = 1'b1;
				if (stat.clock_done)
					state_d = S_COMMIT;
			end
			S_LRU: begin
				cmd.lru_step = 1'b1;
				if (stat.lru_last)
					state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ----- src/pfar_dp.sv -----
module pfar_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pfar_pkg::pfar_cmd_t                cmd,
	output pfar_pkg::pfar_stat_t               stat,
	input  logic [1:0]                         req_user,
	input  logic [pfar_pkg::IN_DATA_W-1:0]     req_data,
	input  logic                               cfg_valid,
	input  logic                               cfg_data,
	output logic                               res_valid,
	input  logic                               res_ready,
	output logic [2:0]                         res_user,
	output logic [pfar_pkg::OUT_DATA_W-1:0]    res_data
);
	import pfar_pkg::*;

	// latched request
	logic [1:0] cmd_q;
	logic [7:0] tag_q;
	logic [7:0] page_q;
	logic [3:0] fi_q;
	logic       wr_q;

	// frame table
	logic [FRAME_COUNT-1:0] in_use_q;
	logic [FRAME_COUNT-1:0] ref_q;
	logic [FRAME_COUNT-1:0] mod_q;
	logic [7:0]             owner_q [FRAME_COUNT];
	logic [7:0]             opage_q [FRAME_COUNT];
	stamp_t                 stamp_q [FRAME_COUNT];

	idx_t   hand_q;
	stamp_t time_q;
	free_t  free_q;
	logic   use_lru_q;

	// search state
	idx_t   pos_q;
	logic [1:0] pass_q;
	idx_t   victim_q;
	stamp_t best_stamp_q;

	// output register
	logic        res_valid_q;
	logic [2:0]  res_status_q;
	logic [3:0]  res_frame_q;
	logic [7:0]  res_vown_q;
	logic [7:0]  res_vpage_q;
	logic        res_wb_q;
	logic [4:0]  res_free_q;

	logic   all_used;
	idx_t   free_idx;
	logic   fi_ok;
	idx_t   fi_idx;
	logic   pos_last;
	logic   clk_hit;
	logic   clk_last;
	stamp_t scan_stamp;
	logic   lru_less;
	logic   out_free;

	assign all_used = &in_use_q;

	// lowest free frame
	always_comb begin
		free_idx = '0;
		for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
			if (!in_use_q[i])
				free_idx = idx_t'(i);
		end
	end

	assign fi_ok  = (32'(fi_q) < FRAME_COUNT);
	assign fi_idx = idx_t'(fi_q);

	assign pos_last = (pos_q == idx_t'(FRAME_COUNT - 1));
	assign clk_hit  = in_use_q[hand_q] &&
		({ref_q[hand_q], mod_q[hand_q]} == {1'b0, pass_q[0]});
	assign clk_last = pos_last && (pass_q == 2'd3);

	assign scan_stamp = stamp_q[pos_q];
	assign lru_less   = (scan_stamp < best_stamp_q);

	assign out_free = !res_valid_q || res_ready;

	assign stat.need_evict = (cmd_q == CMD_ALLOC) && all_used;
	assign stat.use_lru    = use_lru_q;
	assign stat.clock_done = clk_hit || clk_last;
	assign stat.lru_last   = pos_last;
	assign stat.out_free   = out_free;

	// result of the committed request
	logic [2:0] r_status;
	logic [3:0] r_frame;
	logic [7:0] r_vown;
	logic [7:0] r_vpage;
	logic       r_wb;
	free_t      r_free;
	idx_t       alloc_idx;

	assign alloc_idx = all_used ? victim_q : free_idx;

	always_comb begin
		r_status = ST_NOP;
		r_frame  = fi_q;
		r_vown   = '0;
		r_vpage  = '0;
		r_wb     = 1'b0;
		r_free   = free_q;
		unique case (cmd_q)
			CMD_ALLOC: begin
				r_frame = 4'(alloc_idx);
				if (all_used) begin
					r_status = ST_ALLOC_EVICT;
					r_vown   = owner_q[victim_q];
					r_vpage  = opage_q[victim_q];
					r_wb     = mod_q[victim_q];
				end else begin
					r_status = ST_ALLOC_FREE;
					r_free   = free_q - free_t'(1);
				end
			end
			CMD_FREE: begin
				if (fi_ok && in_use_q[fi_idx]) begin
					r_status = ST_FREED;
					r_free   = free_q + free_t'(1);
				end
			end
			CMD_ACCESS: begin
				if (fi_ok && in_use_q[fi_idx])
					r_status = ST_ACCESSED;
			end
			default: r_status = ST_NOP;
		endcase
	end

	// request latch and search registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= req_user;
			tag_q  <= req_data[7:0];
			page_q <= req_data[15:8];
			fi_q   <= req_data[19:16];
			wr_q   <= req_data[20];
		end
		if (cmd.start_clock) begin
			pos_q  <= '0;
			pass_q <= 2'd0;
		end else if (cmd.clock_step) begin
			pos_q <= pos_last ? '0 : pos_q + idx_t'(1);
			if (pos_last)
				pass_q <= pass_q + 2'd1;
			if (clk_hit)
				victim_q <= hand_q;
			else if (clk_last)
				victim_q <= adv_hand(hand_q);
		end else if (cmd.start_lru) begin
			pos_q        <= idx_t'(1);
			victim_q     <= '0;
			best_stamp_q <= stamp_q[0];
		end else if (cmd.lru_step) begin
			pos_q <= pos_q + idx_t'(1);
			if (lru_less) begin
				victim_q     <= pos_q;
				best_stamp_q <= scan_stamp;
			end
		end
	end

	// owner fields: no reset, read only once every frame was allocated
	always_ff @(posedge clk) begin
		if (cmd.commit && (cmd_q == CMD_ALLOC)) begin
			owner_q[alloc_idx] <= tag_q;
			opage_q[alloc_idx] <= page_q;
		end
	end

	// table control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q  <= '0;
			ref_q     <= '0;
			mod_q     <= '0;
			hand_q    <= '0;
			time_q    <= '0;
			free_q    <= free_t'(FRAME_COUNT);
			use_lru_q <= 1'b0;
			for (int i = 0; i < FRAME_COUNT; i++)
				stamp_q[i] <= '0;
		end else begin
			if (cfg_valid)
				use_lru_q <= cfg_data;
			if (cmd.clock_step) begin
				if (in_use_q[hand_q] && !clk_hit && ref_q[hand_q])
					ref_q[hand_q] <= 1'b0;
				if (!clk_hit && clk_last)
					hand_q <= adv_hand(adv_hand(hand_q));
				else
					hand_q <= adv_hand(hand_q);
			end
			if (cmd.commit) begin
				free_q <= r_free;
				unique case (cmd_q)
					CMD_ALLOC: begin
						in_use_q[alloc_idx] <= 1'b1;
						ref_q[alloc_idx]    <= 1'b0;
						mod_q[alloc_idx]    <= 1'b0;
					end
					CMD_FREE: begin
						if (fi_ok && in_use_q[fi_idx])
							in_use_q[fi_idx] <= 1'b0;
					end
					CMD_ACCESS: begin
						if (fi_ok && in_use_q[fi_idx]) begin
							ref_q[fi_idx]   <= 1'b1;
							if (wr_q)
								mod_q[fi_idx] <= 1'b1;
							stamp_q[fi_idx] <= time_q;
							time_q          <= time_q + stamp_t'(1);
						end
					end
					default: ;
				endcase
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (cmd.commit)
			res_valid_q <= 1'b1;
		else if (res_ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_status_q <= r_status;
			res_frame_q  <= r_frame;
			res_vown_q   <= r_vown;
			res_vpage_q  <= r_vpage;
			res_wb_q     <= r_wb;
			res_free_q   <= 5'(r_free);
		end
	end

	assign res_valid = res_valid_q;
	assign res_user  = res_status_q;
	assign res_data  = {6'b0, res_free_q, res_wb_q, res_vpage_q, res_vown_q, res_frame_q};

endmodule
